### hw/rtl/fm3_pkg.sv
// ----------------------------------------------------------------------------
// fm3_pkg: shared types and constants of the focus measure filter
// Sizes, register indexes, method codes and the gradient bundle passed
// between the window front end and the focus back end.
// ----------------------------------------------------------------------------
package fm3_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;

  // Counter and size widths
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
  localparam int HCNT_W = $clog2(MAX_HEIGHT + 1);

  // Field and register widths
  localparam int PIX_W      = 8;
  localparam int FOCUS_W    = 8;
  localparam int OUT_COL_W  = 11;
  localparam int OUT_ROW_W  = 12;
  localparam int MODE_W     = 2;
  localparam int IMG_W_W    = 12;
  localparam int IMG_H_W    = 13;
  localparam int THR_W      = 8;
  localparam int THR_SQ_W   = 2 * THR_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Line store word: upper row pixel on top, middle row pixel below
  localparam int LINE_W = 2 * PIX_W;

  // Gradient widths: |gx|, |gy| <= 1020, |laplacian| <= 2040
  localparam int GRAD_W = 11;
  localparam int LAP_W  = 11;
  localparam int ABS_W  = GRAD_W - 1;
  localparam int SQ_W   = 2 * ABS_W;
  localparam int SUM_W  = 13;

  // Register reset values
  localparam logic [MODE_W-1:0]   MODE_RST   = 2'd0;
  localparam logic [IMG_W_W-1:0]  WIDTH_RST  = 12'd640;
  localparam logic [IMG_H_W-1:0]  HEIGHT_RST = 13'd480;
  localparam logic [THR_W-1:0]    THR_RST    = 8'd30;
  localparam logic [THR_SQ_W-1:0] THR_SQ_RST = THR_SQ_W'(int'(THR_RST) * int'(THR_RST));

  localparam logic [FOCUS_W-1:0] FOCUS_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOCUS_MODE     = 2'd0,
    CFG_IMAGE_WIDTH    = 2'd1,
    CFG_IMAGE_HEIGHT   = 2'd2,
    CFG_GRAD_THRESHOLD = 2'd3
  } cfg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_LAPLACE   = 2'd0,
    MODE_SOBEL     = 2'd1,
    MODE_TENENGRAD = 2'd2
  } mode_e;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic [LAP_W-1:0]         lap_abs;
    logic                     interior;
    logic [OUT_COL_W-1:0]     col;
    logic [OUT_ROW_W-1:0]     row;
    logic                     last;
  } grad_t;

  typedef struct packed {
    logic [SQ_W-1:0]      sqx;
    logic [SQ_W-1:0]      sqy;
    logic [FOCUS_W-1:0]   sobel;
    logic [FOCUS_W-1:0]   lap;
    logic                 interior;
    logic [OUT_COL_W-1:0] col;
    logic [OUT_ROW_W-1:0] row;
    logic                 last;
  } energy_t;

endpackage

### hw/rtl/focus_measure_3x3_filter.sv
// ----------------------------------------------------------------------------
// focus_measure_3x3_filter: 3x3 focus measure over a gray pixel stream
// Laplacian, Sobel L1 or thresholded Tenengrad over a line-buffered window.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one 8-bit gray pixel per item
//   in raster order; frame_start_i puts the item at column 0, row 0. Counters
//   also wrap on their own after the last pixel of a frame.
//   Output channel (out_valid_o/out_ready_i) gives one item for each pixel at
//   (x,y) with x,y >= 1: the focus value of position (x-1,y-1), zero on the
//   top row and left column; the right column and bottom row are not sent.
//   Throughput is one item per clock while the receiver does not stall.
//   After its pixel is accepted, a result passes the line store read,
//   gradient, energy and output registers; line store reads use the
//   registered read of one RAM holding both previous rows, 2048 entries deep.
//   When the receiver stalls, the pipeline fills and in_ready_o falls once
//   the line store stage holds an item that cannot move on.
//   Reset clears the counters, the window and the pipeline, and loads mode 0,
//   width 640, height 480 and threshold 30. The line store needs no clearing:
//   every entry that feeds a result is written before it is read. Write
//   configuration only while no item is in flight.
// ----------------------------------------------------------------------------
module focus_measure_3x3_filter
  import fm3_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [PIX_W-1:0]      pixel_i,
  input  logic                  frame_start_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [FOCUS_W-1:0]    focus_o,
  output logic [OUT_COL_W-1:0]  out_col_o,
  output logic [OUT_ROW_W-1:0]  out_row_o,
  output logic                  frame_last_o
);

  logic [MODE_W-1:0]   focus_mode_q;
  logic [IMG_W_W-1:0]  image_width_q;
  logic [IMG_H_W-1:0]  image_height_q;
  logic [THR_SQ_W-1:0] thr_sq_q;

  logic [WCNT_W-1:0] width_c;
  logic [HCNT_W-1:0] height_c;

  logic  grad_valid, grad_ready;
  grad_t grad;

  // Threshold is kept squared; the compare needs nothing else
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focus_mode_q   <= MODE_RST;
      image_width_q  <= WIDTH_RST;
      image_height_q <= HEIGHT_RST;
      thr_sq_q       <= THR_SQ_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FOCUS_MODE:     focus_mode_q   <= cfg_data_i[MODE_W-1:0];
        CFG_IMAGE_WIDTH:    image_width_q  <= cfg_data_i[IMG_W_W-1:0];
        CFG_IMAGE_HEIGHT:   image_height_q <= cfg_data_i[IMG_H_W-1:0];
        CFG_GRAD_THRESHOLD: thr_sq_q <= THR_SQ_W'(cfg_data_i[THR_W-1:0]) *
                                        THR_SQ_W'(cfg_data_i[THR_W-1:0]);
        default: ;
      endcase
    end
  end

  // Saturate frame size to the supported range
  always_comb begin
    if (image_width_q < IMG_W_W'(3)) begin
      width_c = WCNT_W'(3);
    end else if (int'(image_width_q) > MAX_WIDTH) begin
      width_c = WCNT_W'(MAX_WIDTH);
    end else begin
      width_c = WCNT_W'(image_width_q);
    end

    if (image_height_q < IMG_H_W'(3)) begin
      height_c = HCNT_W'(3);
    end else if (int'(image_height_q) > MAX_HEIGHT) begin
      height_c = HCNT_W'(MAX_HEIGHT);
    end else begin
      height_c = HCNT_W'(image_height_q);
    end
  end

  fm3_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .width_i       (width_c),
    .height_i      (height_c),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_i       (pixel_i),
    .frame_start_i (frame_start_i),
    .grad_valid_o  (grad_valid),
    .grad_ready_i  (grad_ready),
    .grad_o        (grad)
  );

  fm3_focus u_focus (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .focus_mode_i (focus_mode_q),
    .thr_sq_i     (thr_sq_q),
    .grad_valid_i (grad_valid),
    .grad_ready_o (grad_ready),
    .grad_i       (grad),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .focus_o      (focus_o),
    .out_col_o    (out_col_o),
    .out_row_o    (out_row_o),
    .frame_last_o (frame_last_o)
  );

endmodule

### hw/rtl/fm3_ram.sv
// ----------------------------------------------------------------------------
// fm3_ram: simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module fm3_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/fm3_front.sv
// ----------------------------------------------------------------------------
// fm3_front: position counters, line store and 3x3 window
// Reads the two stored rows at the pixel's column, shifts the window and forms
// the Sobel gradients and the Laplacian, one item per cycle when not stalled.
// ----------------------------------------------------------------------------
module fm3_front
  import fm3_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [WCNT_W-1:0] width_i,
  input  logic [HCNT_W-1:0] height_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [PIX_W-1:0]  pixel_i,
  input  logic              frame_start_i,
  output logic              grad_valid_o,
  input  logic              grad_ready_i,
  output grad_t             grad_o
);

  // Position counters
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;

  logic [COL_W-1:0]  col_base, x0;
  logic [ROW_W-1:0]  row_base, y0;
  logic [WCNT_W-1:0] x_inc;
  logic [HCNT_W-1:0] y_inc;
  logic              wrap;
  logic              accept;
  logic              emit0, interior0, last0;

  // Line store stage
  logic                 v1_q, emit1_q, int1_q, last1_q, byp1_q;
  logic [PIX_W-1:0]     px1_q;
  logic [COL_W-1:0]     x1_q;
  logic [OUT_COL_W-1:0] ocol1_q;
  logic [OUT_ROW_W-1:0] orow1_q;
  logic [LINE_W-1:0]    bypd_q;
  logic [LINE_W-1:0]    ram_rdata, line_rd, wr_word;
  logic [PIX_W-1:0]     u_px, m_px;
  logic                 s1_adv, s2_free;

  // Window: entries 0..2 column x-2, 3..5 column x-1, top to bottom
  logic [PIX_W-1:0] win_q [6];

  // Gradient stage
  logic  v2_q;
  grad_t grad_q, grad_d;

  logic [SUM_W-1:0]        sum_a, sum_c, sum_t, sum_b, sum_n, cen8;
  logic signed [SUM_W-1:0] gx_w, gy_w, lap_w;

  // ---------------------------------------------------------------------------
  // Position of the incoming pixel
  // ---------------------------------------------------------------------------
  always_comb begin
    col_base = frame_start_i ? '0 : col_q;
    row_base = frame_start_i ? '0 : row_q;
    x0 = (WCNT_W'(col_base) >= width_i) ? '0 : col_base;
    y0 = (HCNT_W'(row_base) >= height_i) ? '0 : row_base;

    x_inc = WCNT_W'(x0) + WCNT_W'(1);
    y_inc = HCNT_W'(y0) + HCNT_W'(1);
    wrap  = (x_inc >= width_i);
    col_d = wrap ? '0 : x_inc[COL_W-1:0];
    if (wrap) begin
      row_d = (y_inc >= height_i) ? '0 : y_inc[ROW_W-1:0];
    end else begin
      row_d = y0;
    end

    emit0     = (x0 != '0) && (y0 != '0);
    interior0 = (x0 >= COL_W'(2)) && (y0 >= ROW_W'(2));
    last0     = (WCNT_W'(x0) == width_i - WCNT_W'(1)) &&
                (HCNT_W'(y0) == height_i - HCNT_W'(1));
  end

  // Stall chain: items without a result leave the line store stage freely
  assign s2_free    = !v2_q || grad_ready_i;
  assign s1_adv     = v1_q && (!emit1_q || s2_free);
  assign in_ready_o = !v1_q || s1_adv;
  assign accept     = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // Line store: read at acceptance, write back when the item moves on
  // ---------------------------------------------------------------------------
  assign line_rd = byp1_q ? bypd_q : ram_rdata;
  assign u_px    = line_rd[LINE_W-1:PIX_W];
  assign m_px    = line_rd[PIX_W-1:0];
  assign wr_word = {m_px, px1_q};

  fm3_ram #(
    .Width (LINE_W),
    .Depth (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (x1_q),
    .wdata_i (wr_word),
    .re_i    (accept),
    .raddr_i (x0),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      v1_q    <= 1'b0;
      emit1_q <= 1'b0;
      byp1_q  <= 1'b0;
    end else begin
      if (accept) begin
        col_q   <= col_d;
        row_q   <= row_d;
        emit1_q <= emit0;
        // Forward the word written in the same cycle as the read
        byp1_q  <= s1_adv && (x1_q == x0);
      end
      if (accept) begin
        v1_q <= 1'b1;
      end else if (s1_adv) begin
        v1_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px1_q   <= pixel_i;
      x1_q    <= x0;
      int1_q  <= interior0;
      last1_q <= last0;
      ocol1_q <= OUT_COL_W'(x0 - COL_W'(1));
      orow1_q <= OUT_ROW_W'(y0 - ROW_W'(1));
      bypd_q  <= wr_word;
    end
  end

  // ---------------------------------------------------------------------------
  // Window shift and gradients
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_adv) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= u_px;
      win_q[4] <= m_px;
      win_q[5] <= px1_q;
    end
  end

  always_comb begin
    sum_a = SUM_W'(win_q[0]) + SUM_W'({win_q[1], 1'b0}) + SUM_W'(win_q[2]);
    sum_c = SUM_W'(u_px) + SUM_W'({m_px, 1'b0}) + SUM_W'(px1_q);
    sum_t = SUM_W'(win_q[0]) + SUM_W'({win_q[3], 1'b0}) + SUM_W'(u_px);
    sum_b = SUM_W'(win_q[2]) + SUM_W'({win_q[5], 1'b0}) + SUM_W'(px1_q);
    sum_n = SUM_W'(win_q[0]) + SUM_W'(win_q[1]) + SUM_W'(win_q[2]) +
            SUM_W'(win_q[3]) + SUM_W'(win_q[5]) +
            SUM_W'(u_px) + SUM_W'(m_px) + SUM_W'(px1_q);
    cen8  = SUM_W'({win_q[4], 3'b000});

    gx_w  = signed'(sum_c - sum_a);
    gy_w  = signed'(sum_b - sum_t);
    lap_w = signed'(cen8 - sum_n);

    grad_d.gx       = gx_w[GRAD_W-1:0];
    grad_d.gy       = gy_w[GRAD_W-1:0];
    grad_d.lap_abs  = lap_w[SUM_W-1] ? LAP_W'(-lap_w) : LAP_W'(lap_w);
    grad_d.interior = int1_q;
    grad_d.col      = ocol1_q;
    grad_d.row      = orow1_q;
    grad_d.last     = last1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (s1_adv && emit1_q) begin
      v2_q <= 1'b1;
    end else if (grad_ready_i) begin
      v2_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && emit1_q) begin
      grad_q <= grad_d;
    end
  end

  assign grad_valid_o = v2_q;
  assign grad_o       = grad_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_emit_reaches_grad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && emit1_q) |=> v2_q)
    else $error("result item lost between line store and gradient stage");

  // Border items may carry unknown gradients, so compare bit for bit
  a_grad_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !grad_ready_i) |=> (v2_q && (grad_q === $past(grad_q))))
    else $error("stalled gradient item changed");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !s1_adv) |-> !in_ready_o)
    else $error("input taken while line store write is pending");

  a_bypass_same_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s1_adv && (x1_q == x0)) |=> byp1_q)
    else $error("same-column read after write not forwarded");

endmodule

### hw/rtl/fm3_focus.sv
// ----------------------------------------------------------------------------
// fm3_focus: focus value from gradients
// Squares and absolute sums in one stage, method select and Tenengrad
// threshold compare into the result register.
// ----------------------------------------------------------------------------
module fm3_focus
  import fm3_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [MODE_W-1:0]    focus_mode_i,
  input  logic [THR_SQ_W-1:0]  thr_sq_i,
  input  logic                 grad_valid_i,
  output logic                 grad_ready_o,
  input  grad_t                grad_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [FOCUS_W-1:0]   focus_o,
  output logic [OUT_COL_W-1:0] out_col_o,
  output logic [OUT_ROW_W-1:0] out_row_o,
  output logic                 frame_last_o
);

  logic    v3_q, vo_q;
  logic    o_free, s3_free, s3_adv, s2_adv;
  energy_t en_q, en_d;

  logic [ABS_W-1:0]     abs_x, abs_y;
  logic [ABS_W:0]       l1;
  logic [SQ_W:0]        energy;
  logic [FOCUS_W-1:0]   tenen, focus_d;

  logic [FOCUS_W-1:0]   focus_q;
  logic [OUT_COL_W-1:0] col_q;
  logic [OUT_ROW_W-1:0] row_q;
  logic                 last_q;

  assign o_free       = !vo_q || out_ready_i;
  assign s3_free      = !v3_q || o_free;
  assign s3_adv       = v3_q && o_free;
  assign s2_adv       = grad_valid_i && s3_free;
  assign grad_ready_o = s3_free;

  // ---------------------------------------------------------------------------
  // Squares, Sobel L1 and Laplacian clamp
  // ---------------------------------------------------------------------------
  always_comb begin
    abs_x = grad_i.gx[GRAD_W-1] ? ABS_W'(-grad_i.gx) : ABS_W'(grad_i.gx);
    abs_y = grad_i.gy[GRAD_W-1] ? ABS_W'(-grad_i.gy) : ABS_W'(grad_i.gy);
    l1    = (ABS_W+1)'(abs_x) + (ABS_W+1)'(abs_y);

    en_d.sqx      = SQ_W'(abs_x) * SQ_W'(abs_x);
    en_d.sqy      = SQ_W'(abs_y) * SQ_W'(abs_y);
    en_d.sobel    = FOCUS_W'(l1 >> 4);
    en_d.lap      = (grad_i.lap_abs > LAP_W'(FOCUS_MAX)) ? FOCUS_MAX
                                                         : grad_i.lap_abs[FOCUS_W-1:0];
    en_d.interior = grad_i.interior;
    en_d.col      = grad_i.col;
    en_d.row      = grad_i.row;
    en_d.last     = grad_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (s2_adv) begin
      v3_q <= 1'b1;
    end else if (o_free) begin
      v3_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      en_q <= en_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Method select
  // ---------------------------------------------------------------------------
  always_comb begin
    energy = (SQ_W+1)'(en_q.sqx) + (SQ_W+1)'(en_q.sqy);
    if (energy > (SQ_W+1)'(thr_sq_i)) begin
      tenen = (energy[SQ_W:8] > (SQ_W-7)'(FOCUS_MAX)) ? FOCUS_MAX
                                                      : energy[FOCUS_W+7:8];
    end else begin
      tenen = '0;
    end

    case (focus_mode_i)
      MODE_LAPLACE:   focus_d = en_q.lap;
      MODE_SOBEL:     focus_d = en_q.sobel;
      MODE_TENENGRAD: focus_d = tenen;
      default:        focus_d = '0;
    endcase
    // Border positions carry zero
    if (!en_q.interior) begin
      focus_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (s3_adv) begin
      vo_q <= 1'b1;
    end else if (out_ready_i) begin
      vo_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_adv) begin
      focus_q <= focus_d;
      col_q   <= en_q.col;
      row_q   <= en_q.row;
      last_q  <= en_q.last;
    end
  end

  assign out_valid_o  = vo_q;
  assign focus_o      = focus_q;
  assign out_col_o    = col_q;
  assign out_row_o    = row_q;
  assign frame_last_o = last_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_border_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_adv && !en_q.interior) |=> (focus_o == '0))
    else $error("border result carries a nonzero focus value");

  a_s3_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_adv |=> vo_q)
    else $error("result item lost before output register");

  // Border items may carry unknown energies, so compare bit for bit
  a_s3_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !o_free) |=> (v3_q && (en_q === $past(en_q))))
    else $error("stalled energy stage changed");

endmodule

### dv/focus_measure_3x3_filter_tb.sv
// ----------------------------------------------------------------------------
// focus_measure_3x3_filter_tb: self-checking bench of the 3x3 focus filter
// Streams gray frames in raster order through the valid/ready channels under
// several register settings. A predictor keeps its own line stores, window
// and position counters, and every result is checked in order, field by
// field. Short directed frames come first, then random frames with random
// idling on both channels, a long receiver stall and a pause to drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module focus_measure_3x3_filter_tb
  import fm3_pkg::*;
;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int RX_HOLD_LEN   = 300;
  localparam int MAX_REPORTS   = 50;

  typedef struct {
    logic [FOCUS_W-1:0]   focus;
    logic [OUT_COL_W-1:0] col;
    logic [OUT_ROW_W-1:0] row;
    logic                 last;
  } focus_exp_t;

  // Predicts focus results from accepted pixels and checks the output items.
  class focus_scoreboard;
    logic [PIX_W-1:0] store_upper [MAX_WIDTH];
    logic [PIX_W-1:0] store_middle[MAX_WIDTH];
    logic [PIX_W-1:0] win[6];
    int unsigned col_cnt, row_cnt;
    logic [MODE_W-1:0]  mode_reg;
    logic [IMG_W_W-1:0] width_reg;
    logic [IMG_H_W-1:0] height_reg;
    logic [THR_W-1:0]   thr_reg;
    focus_exp_t pending_focus[$];
    int errors;
    int checked;

    function new();
      for (int i = 0; i < MAX_WIDTH; i++) begin
        store_upper[i]  = '0;
        store_middle[i] = '0;
      end
      for (int i = 0; i < 6; i++) win[i] = '0;
      col_cnt    = 0;
      row_cnt    = 0;
      mode_reg   = MODE_RST;
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      thr_reg    = THR_RST;
      errors     = 0;
      checked    = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_FOCUS_MODE:     mode_reg   = d[MODE_W-1:0];
        CFG_IMAGE_WIDTH:    width_reg  = d[IMG_W_W-1:0];
        CFG_IMAGE_HEIGHT:   height_reg = d[IMG_H_W-1:0];
        CFG_GRAD_THRESHOLD: thr_reg    = d[THR_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_focus.size();
    endfunction

    function void accept_pixel(logic [PIX_W-1:0] px, logic fs);
      int unsigned w, h, x, y;
      int a0, a1, a2, b0, b1, b2, c0, c1, c2;
      int gx, gy, lap, e, t;
      logic [PIX_W-1:0] up, mid;
      focus_exp_t exp_r;
      w = (width_reg < 3) ? 3 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
      h = (height_reg < 3) ? 3 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
      if (fs) begin
        col_cnt = 0;
        row_cnt = 0;
      end
      if (col_cnt >= w) col_cnt = 0;
      if (row_cnt >= h) row_cnt = 0;
      x   = col_cnt;
      y   = row_cnt;
      up  = store_upper[x % MAX_WIDTH];
      mid = store_middle[x % MAX_WIDTH];

      if (x >= 1 && y >= 1) begin
        exp_r.focus = '0;
        if (x >= 2 && y >= 2) begin
          // a: column x-2, b: column x-1, c: column x; index 0 is the top row
          a0 = win[0]; a1 = win[1]; a2 = win[2];
          b0 = win[3]; b1 = win[4]; b2 = win[5];
          c0 = up;     c1 = mid;    c2 = px;
          gx = (c0 + 2 * c1 + c2) - (a0 + 2 * a1 + a2);
          gy = (a2 + 2 * b2 + c2) - (a0 + 2 * b0 + c0);
          case (mode_reg)
            MODE_LAPLACE: begin
              lap = 8 * b1 - (a0 + a1 + a2 + b0 + b2 + c0 + c1 + c2);
              if (lap < 0) lap = -lap;
              exp_r.focus = (lap > 255) ? FOCUS_MAX : lap[FOCUS_W-1:0];
            end
            MODE_SOBEL: begin
              e = ((gx < 0) ? -gx : gx) + ((gy < 0) ? -gy : gy);
              e = e >> 4;
              exp_r.focus = (e > 255) ? FOCUS_MAX : e[FOCUS_W-1:0];
            end
            MODE_TENENGRAD: begin
              e = gx * gx + gy * gy;
              t = thr_reg;
              if (e > t * t) begin
                e = e >> 8;
                exp_r.focus = (e > 255) ? FOCUS_MAX : e[FOCUS_W-1:0];
              end
            end
            default: exp_r.focus = '0;
          endcase
        end
        exp_r.col  = OUT_COL_W'(x - 1);
        exp_r.row  = OUT_ROW_W'(y - 1);
        exp_r.last = (x == w - 1) && (y == h - 1);
        pending_focus.push_back(exp_r);
      end

      store_upper[x % MAX_WIDTH]  = mid;
      store_middle[x % MAX_WIDTH] = px;
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = up;
      win[4] = mid;
      win[5] = px;

      col_cnt = x + 1;
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt = y + 1;
        if (row_cnt >= h) row_cnt = 0;
      end
    endfunction

    function void report(string what, int exp_v, int act_v);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
    endfunction

    function void check_focus(logic [FOCUS_W-1:0] f, logic [OUT_COL_W-1:0] c,
                              logic [OUT_ROW_W-1:0] r, logic l);
      focus_exp_t exp_r;
      if (pending_focus.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual focus %0d at (%0d,%0d)",
                   $time, f, c, r);
        return;
      end
      exp_r = pending_focus.pop_front();
      checked++;
      if (f !== exp_r.focus) report("focus", exp_r.focus, f);
      if (c !== exp_r.col)   report("out_col", exp_r.col, c);
      if (r !== exp_r.row)   report("out_row", exp_r.row, r);
      if (l !== exp_r.last)  report("frame_last", exp_r.last, l);
    endfunction
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_ready_o;
  logic [PIX_W-1:0]      pixel_i       = '0;
  logic                  frame_start_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i   = 1'b0;
  logic [FOCUS_W-1:0]    focus_o;
  logic [OUT_COL_W-1:0]  out_col_o;
  logic [OUT_ROW_W-1:0]  out_row_o;
  logic                  frame_last_o;

  focus_scoreboard sb;
  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int rx_hold_len  = 0;
  int pixels_sent  = 0;
  int settings_run = 0;

  focus_measure_3x3_filter u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pixel_i      (pixel_i),
    .frame_start_i(frame_start_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .focus_o      (focus_o),
    .out_col_o    (out_col_o),
    .out_row_o    (out_row_o),
    .frame_last_o (frame_last_o)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    #10_000_000;
    $display("focus_measure_3x3_filter_tb: done, errors");
    $finish;
  end

  // Receiver: random ready, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i)
        sb.check_focus(focus_o, out_col_o, out_row_o, frame_last_o);
      if (rx_hold_len != 0) begin
        out_ready_i <= 1'b0;
        repeat (rx_hold_len) @(posedge clk_i);
        rx_hold_len = 0;
      end
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid_i    <= 1'b1;
    pixel_i       <= px;
    frame_start_i <= fs;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.accept_pixel(px, fs);
    pixels_sent++;
  endtask

  // Drop valid and wait until every predicted result has come back or the drain limit is reached
  task automatic drain_focus();
    int n;
    n = 0;
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
      n++;
    end while (sb.pending() != 0 && n < DRAIN_LIMIT);
  endtask

  task automatic program_regs(input logic [MODE_W-1:0] mode, input int w_raw,
                              input int h_raw, input logic [THR_W-1:0] thr);
    logic [CFG_DATA_W-1:0] d[4];
    cfg_idx_e idx[4];
    // Random upper bits above the mode, width and threshold fields are ignored by the block
    d[0] = {11'($urandom), mode};
    d[1] = {1'($urandom_range(1)), 12'(w_raw)};
    d[2] = 13'(h_raw);
    d[3] = {5'($urandom), thr};
    idx[0] = CFG_FOCUS_MODE;
    idx[1] = CFG_IMAGE_WIDTH;
    idx[2] = CFG_IMAGE_HEIGHT;
    idx[3] = CFG_GRAD_THRESHOLD;
    drain_focus();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= d[i];
      @(posedge clk_i);
      sb.set_reg(idx[i], d[i]);
    end
    cfg_we_i <= 1'b0;
    settings_run++;
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(3))
      0: return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
      1: return 8'(112 + $urandom_range(32));
      default: return 8'($urandom);
    endcase
  endfunction

  // Raster stream opened by a frame start; a stray frame start now and then
  task automatic run_stream(input int n, input int pause_at);
    for (int i = 0; i < n; i++) begin
      if (i == pause_at && i != 0) drain_focus();
      send_pixel(rand_pixel(), (i == 0) || ($urandom_range(99) == 0));
    end
  endtask

  initial begin
    int n;
    int w_raw, h_raw;
    logic [THR_W-1:0] thr;
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 20;
    rx_idle_pct = 74;

    // Isolated bright center: Laplacian saturates
    program_regs(MODE_LAPLACE, 3, 3, 8'd30);
    for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 8'hFF : 8'h00, i == 0);
    // Vertical step edge: largest horizontal gradient
    program_regs(MODE_SOBEL, 3, 3, 8'd30);
    for (int i = 0; i < 9; i++) send_pixel((i % 3 == 0) ? 8'h00 : 8'hFF, i == 0);
    program_regs(MODE_TENENGRAD, 3, 3, 8'hFF);
    for (int i = 0; i < 9; i++) send_pixel((i % 3 == 0) ? 8'h00 : 8'hFF, i == 0);

    for (int r = 0; r < 3; r++) begin
      tx_idle_pct = (r == 0) ? 20 : ((r == 1) ? 74 : 0);
      rx_idle_pct = (r == 0) ? 74 : ((r == 1) ? 20 : 0);
      for (int p = 0; p < 6; p++) begin
        thr   = (p == 0) ? 8'h00 : ((p == 1) ? 8'hFF : 8'($urandom));
        w_raw = $urandom_range(14);
        h_raw = $urandom_range(8);
        program_regs(MODE_W'(p % 4), w_raw, h_raw, thr);
        if (r == 0 && p == 2) rx_hold_len = RX_HOLD_LEN;
        n = $urandom_range(70, 30);
        run_stream(n, (r == 1 && p == 3) ? n / 2 : 0);
      end
    end

    // Size extremes: widest row, tallest frame, sizes below range
    program_regs(MODE_W'($urandom_range(2)), 4095, 3, 8'($urandom));
    run_stream(200, 0);
    program_regs(MODE_SOBEL, 3, 8191, 8'($urandom));
    run_stream(120, 0);
    program_regs(MODE_UNUSED, 0, 0, 8'($urandom));
    run_stream(30, 0);
    program_regs(MODE_LAPLACE, 1, 2, 8'($urandom));
    run_stream(30, 0);

    drain_focus();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
    end
    $display("Streamed %0d pixels under %0d register settings, %0d focus results checked,",
             pixels_sent, settings_run, sb.checked);
    $display("covering all four modes, size saturation, frame wrap and stray frame starts.");
    if (sb.errors == 0)
      $display("focus_measure_3x3_filter_tb: done, clean");
    else
      $display("focus_measure_3x3_filter_tb: done, errors");
    $finish;
  end

endmodule
